@@ sv/hecs_pkg.sv @@
// hecs_pkg: shared constants, widths and helpers for the hall edge counter
// and speed block. Used by hecs_tracker and hall_edge_counter_speed.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hecs_pkg;

    // fixed field widths
    localparam int CFG_BITS       = 24;
    localparam int CFG_INDEX_BITS = 1;
    localparam int PULSE_BITS     = 16;
    localparam int POS_OUT_BITS   = 32;
    localparam int SPEED_BITS     = 40;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SAMPLES = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RPM_FACTOR     = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 24'd250000;
    localparam logic [CFG_BITS-1:0] FACTOR_RESET = 24'd7680;

    typedef logic [2:0] t_phase;

    localparam t_phase PHASE_NONE = 3'd0;
    localparam t_phase PHASE_1    = 3'd1;
    localparam t_phase PHASE_2    = 3'd2;
    localparam t_phase PHASE_3    = 3'd3;
    localparam t_phase PHASE_4    = 3'd4;

    // level pair to phase: 01 -> 1, 11 -> 2, 10 -> 3, 00 -> 4 (a first)
    function automatic t_phase phase_of(input logic a, input logic b);
        t_phase ph;
        case ({a, b})
            2'b01:   ph = PHASE_1;
            2'b11:   ph = PHASE_2;
            2'b10:   ph = PHASE_3;
            default: ph = PHASE_4;
        endcase
        return ph;
    endfunction

    // direction of travel between two phases, wrap-round handled explicitly
    function automatic logic phase_up(input t_phase ph, input t_phase last);
        logic up;
        up = ((ph > last) && !((ph == PHASE_4) && (last == PHASE_1)))
            || ((ph == PHASE_1) && (last == PHASE_4));
        return up;
    endfunction

endpackage

`default_nettype wire

@@ sv/hecs_tracker.sv @@
// hecs_tracker: edge detection, pulse count, position and window counting,
// with a one-entry report register. Depends on hecs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hecs_tracker #(
    parameter int COUNT_BITS    = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_hall_a,
    input  wire logic                          i_hall_b,
    input  wire logic [hecs_pkg::CFG_BITS-1:0] i_window_samples,
    input  wire logic                          i_rep_take,
    output logic                               o_rep_valid,
    output logic [COUNT_BITS-1:0]              o_rep_count,
    output logic [POSITION_BITS-1:0]           o_rep_position
);

    logic [1:0]                        r_prev_levels;
    hecs_pkg::t_phase                  r_last_phase;
    logic [COUNT_BITS-1:0]             r_edge_count;
    logic [POSITION_BITS-1:0]          r_position;
    logic [hecs_pkg::CFG_BITS-1:0]     r_window_counter;
    logic                              r_rep_valid;
    logic [COUNT_BITS-1:0]             r_rep_count;
    logic [POSITION_BITS-1:0]          r_rep_position;

    logic                              event_hit;
    hecs_pkg::t_phase                  phase_now;
    logic [COUNT_BITS-1:0]             n_edge_count;
    logic [POSITION_BITS-1:0]          n_position;
    logic [hecs_pkg::CFG_BITS-1:0]     win_eff;
    logic [hecs_pkg::CFG_BITS-1:0]     n_window_counter;
    logic                              report;

    always_comb begin
        event_hit = (i_hall_a && !r_prev_levels[0]) || (i_hall_b && !r_prev_levels[1]);
        phase_now = hecs_pkg::phase_of(i_hall_a, i_hall_b);

        n_edge_count = r_edge_count;
        n_position   = r_position;
        if (event_hit) begin
            if (r_edge_count != {COUNT_BITS{1'b1}}) begin
                n_edge_count = r_edge_count + COUNT_BITS'(1);
            end
            if (hecs_pkg::phase_up(phase_now, r_last_phase)) begin
                n_position = r_position + POSITION_BITS'(1);
            end else begin
                n_position = r_position - POSITION_BITS'(1);
            end
        end

        // a zero window acts as one sample
        win_eff          = (i_window_samples == '0) ? hecs_pkg::CFG_BITS'(1) : i_window_samples;
        n_window_counter = r_window_counter + hecs_pkg::CFG_BITS'(1);
        report           = (n_window_counter >= win_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels    <= '0;
            r_last_phase     <= hecs_pkg::PHASE_NONE;
            r_edge_count     <= '0;
            r_position       <= '0;
            r_window_counter <= '0;
            r_rep_valid      <= 1'b0;
        end else begin
            // a new report wins over the take of the old one
            if (i_accept && report) begin
                r_rep_valid <= 1'b1;
            end else if (i_rep_take) begin
                r_rep_valid <= 1'b0;
            end
            if (i_accept) begin
                r_prev_levels <= {i_hall_b, i_hall_a};
                r_position    <= n_position;
                if (event_hit) begin
                    r_last_phase <= phase_now;
                end
                if (report) begin
                    r_window_counter <= '0;
                    r_edge_count     <= '0;
                end else begin
                    r_window_counter <= n_window_counter;
                    r_edge_count     <= n_edge_count;
                end
            end
        end
    end

    // report payload, loaded with the count including this beat's event
    always_ff @(posedge i_clk) begin
        if (i_accept && report) begin
            r_rep_count    <= n_edge_count;
            r_rep_position <= n_position;
        end
    end

    assign o_rep_valid    = r_rep_valid;
    assign o_rep_count    = r_rep_count;
    assign o_rep_position = r_rep_position;

endmodule

`default_nettype wire

@@ sv/hall_edge_counter_speed.sv @@
// hall_edge_counter_speed: top level of the hall sensor edge counter with
// position tracking and windowed speed. Depends on hecs_pkg, hecs_tracker.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one sample of the two
//   hall lines per beat. Output channel (o_out_valid / i_out_stall) carries
//   one report at the end of every window: pulse total, position and speed.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 window_samples, 1 rpm_factor_q16); write only while idle.
//   Throughput: one sample per clock while o_in_stall is low. All per-sample
//   state updates in the cycle the beat is accepted.
//   Report path: the sample that closes the window loads the report register;
//   the report then passes through the count x factor multiply into the
//   output register.
//   Stall: a report waits in the output register while i_out_stall is high;
//   samples keep flowing until a second report is waiting behind it, then
//   o_in_stall rises until the output drains.
//   Reset: synchronous active low; clears all counters and the position,
//   loads window_samples 250000 and rpm_factor_q16 7680.
`timescale 1ns / 1ps
`default_nettype none

module hall_edge_counter_speed #(
    parameter int COUNT_BITS    = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_hall_a,
    input  wire logic                                i_hall_b,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [hecs_pkg::PULSE_BITS-1:0]          o_pulse_total,
    output logic signed [hecs_pkg::POS_OUT_BITS-1:0] o_position_count,
    output logic [hecs_pkg::SPEED_BITS-1:0]          o_speed_q16,
    input  wire logic                                i_cfg_we,
    input  wire logic [hecs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [hecs_pkg::CFG_BITS-1:0]       i_cfg_data
);

    localparam int PROD_BITS = COUNT_BITS + hecs_pkg::CFG_BITS;

    logic [hecs_pkg::CFG_BITS-1:0]     r_window_samples;
    logic [hecs_pkg::CFG_BITS-1:0]     r_rpm_factor;
    logic                              r_out_valid;
    logic [hecs_pkg::PULSE_BITS-1:0]   r_pulse_total;
    logic [hecs_pkg::POS_OUT_BITS-1:0] r_position_count;
    logic [hecs_pkg::SPEED_BITS-1:0]   r_speed;

    logic                              accept;
    logic                              out_adv;
    logic                              rep_valid;
    logic                              rep_take;
    logic [COUNT_BITS-1:0]             rep_count;
    logic [POSITION_BITS-1:0]          rep_position;
    logic [PROD_BITS-1:0]              product;
    logic [hecs_pkg::SPEED_BITS-1:0]   n_speed;
    logic [hecs_pkg::PULSE_BITS-1:0]   n_pulse_total;
    logic [hecs_pkg::POS_OUT_BITS-1:0] n_position_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_samples <= hecs_pkg::WINDOW_RESET;
            r_rpm_factor     <= hecs_pkg::FACTOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hecs_pkg::CFG_WINDOW_SAMPLES: r_window_samples <= i_cfg_data;
                hecs_pkg::CFG_RPM_FACTOR:     r_rpm_factor     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign rep_take   = rep_valid && out_adv;
    // hold samples only when a report is stuck behind a waiting one
    assign o_in_stall = rep_valid && !out_adv;
    assign accept     = i_in_valid && !o_in_stall;

    hecs_tracker #(
        .COUNT_BITS    (COUNT_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_tracker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_hall_a         (i_hall_a),
        .i_hall_b         (i_hall_b),
        .i_window_samples (r_window_samples),
        .i_rep_take       (rep_take),
        .o_rep_valid      (rep_valid),
        .o_rep_count      (rep_count),
        .o_rep_position   (rep_position)
    );

    assign product = PROD_BITS'(rep_count) * PROD_BITS'(r_rpm_factor);

    generate
        if (PROD_BITS >= hecs_pkg::SPEED_BITS) begin : g_speed_trunc
            assign n_speed = product[hecs_pkg::SPEED_BITS-1:0];
        end else begin : g_speed_ext
            assign n_speed = {{(hecs_pkg::SPEED_BITS-PROD_BITS){1'b0}}, product};
        end

        if (COUNT_BITS >= hecs_pkg::PULSE_BITS) begin : g_pulse_trunc
            assign n_pulse_total = rep_count[hecs_pkg::PULSE_BITS-1:0];
        end else begin : g_pulse_ext
            assign n_pulse_total = {{(hecs_pkg::PULSE_BITS-COUNT_BITS){1'b0}}, rep_count};
        end

        // narrow position is sign extended, wide one gives its low bits
        if (POSITION_BITS >= hecs_pkg::POS_OUT_BITS) begin : g_pos_trunc
            assign n_position_count = rep_position[hecs_pkg::POS_OUT_BITS-1:0];
        end else begin : g_pos_ext
            assign n_position_count = {{(hecs_pkg::POS_OUT_BITS-POSITION_BITS){
                rep_position[POSITION_BITS-1]}}, rep_position};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= rep_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rep_take) begin
            r_pulse_total    <= n_pulse_total;
            r_position_count <= n_position_count;
            r_speed          <= n_speed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pulse_total    = r_pulse_total;
    assign o_position_count = r_position_count;
    assign o_speed_q16      = r_speed;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// testbench: self-checking bench for hall_edge_counter_speed. a directed table
// of samples and register writes, then random hall traffic.
// Depends on hecs_pkg and the hall_edge_counter_speed rtl.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [hecs_pkg::PULSE_BITS-1:0]          pulses;
        logic signed [hecs_pkg::POS_OUT_BITS-1:0] position;
        logic [hecs_pkg::SPEED_BITS-1:0]          speed;
    } t_report;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind                           kind;
        logic                                hall_a;
        logic                                hall_b;
        logic [hecs_pkg::CFG_INDEX_BITS-1:0] reg_index;
        logic [hecs_pkg::CFG_BITS-1:0]       reg_value;
        logic                                has_report;
        t_report                             report;
    } t_stim_row;

    localparam t_report NO_REPORT = '0;
    localparam int DIR_ROWS = 29;
    localparam int SEGMENTS = 8;
    localparam int SEG_ITEMS = 105;
    // hall level pairs {a, b} in forward rotation order
    localparam logic [7:0] WALK_LEVELS = {2'b00, 2'b10, 2'b11, 2'b01};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic i_hall_a;
    logic i_hall_b;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [hecs_pkg::PULSE_BITS-1:0] o_pulse_total;
    logic signed [hecs_pkg::POS_OUT_BITS-1:0] o_position_count;
    logic [hecs_pkg::SPEED_BITS-1:0] o_speed_q16;
    logic i_cfg_we;
    logic [hecs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [hecs_pkg::CFG_BITS-1:0] i_cfg_data;

    // predictor state and its copy of the registers
    logic [hecs_pkg::CFG_BITS-1:0]     win_len;
    logic [hecs_pkg::CFG_BITS-1:0]     rpm_factor;
    logic [1:0]                        prev_lv;
    hecs_pkg::t_phase                  last_ph;
    logic [hecs_pkg::PULSE_BITS-1:0]   edges;
    logic [hecs_pkg::POS_OUT_BITS-1:0] position;
    logic [hecs_pkg::CFG_BITS-1:0]     win_cnt;

    t_report   reports_due[$];
    t_stim_row dir_rows [DIR_ROWS];
    logic      beat_typed;
    t_report   beat_expect;
    int        mismatches = 0;
    bit        quiet = 1'b0;
    int        stall_left = 0;

    hall_edge_counter_speed DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_hall_a         (i_hall_a),
        .i_hall_b         (i_hall_b),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pulse_total    (o_pulse_total),
        .o_position_count (o_position_count),
        .o_speed_q16      (o_speed_q16),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one sample through the counter; returns 1 when the window closes
    function automatic bit count_sample(input logic a, input logic b, output t_report rep);
        hecs_pkg::t_phase ph;
        logic up;
        logic [hecs_pkg::CFG_BITS-1:0] span;
        rep = NO_REPORT;
        // simultaneous rise on both lines is still a single event
        if ((a && !prev_lv[0]) || (b && !prev_lv[1])) begin
            case ({a, b})
                2'b01:   ph = hecs_pkg::PHASE_1;
                2'b11:   ph = hecs_pkg::PHASE_2;
                2'b10:   ph = hecs_pkg::PHASE_3;
                default: ph = hecs_pkg::PHASE_4;
            endcase
            if (edges != '1) edges = edges + 1'b1;
            if (last_ph == hecs_pkg::PHASE_NONE) up = 1'b1;
            else if (ph == hecs_pkg::PHASE_1 && last_ph == hecs_pkg::PHASE_4) up = 1'b1;
            else if (ph == hecs_pkg::PHASE_4 && last_ph == hecs_pkg::PHASE_1) up = 1'b0;
            else up = (ph > last_ph);
            position = up ? position + 1'b1 : position - 1'b1;
            last_ph = ph;
        end
        prev_lv = {b, a};
        span = (win_len == '0) ? hecs_pkg::CFG_BITS'(1) : win_len;
        win_cnt = win_cnt + 1'b1;
        if (win_cnt >= span) begin
            win_cnt = '0;
            rep.pulses = edges;
            rep.position = position;
            rep.speed = hecs_pkg::SPEED_BITS'(edges) * hecs_pkg::SPEED_BITS'(rpm_factor);
            edges = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_mismatch(string field, longint want, longint got);
        mismatches++;
        $display("%t %s: expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge i_clk) begin
        t_report rep;
        t_report want;
        bit made;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hecs_pkg::CFG_WINDOW_SAMPLES: win_len = i_cfg_data;
                    hecs_pkg::CFG_RPM_FACTOR:     rpm_factor = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                made = count_sample(i_hall_a, i_hall_b, rep);
                if (beat_typed) reports_due.push_back(beat_expect);
                else if (made) reports_due.push_back(rep);
            end
            if (o_out_valid && !i_out_stall) begin
                if (reports_due.size() == 0) begin
                    mismatches++;
                    $display("%t unexpected report: expected none, got %0d %0d %0d", $time,
                             o_pulse_total, o_position_count, o_speed_q16);
                end else begin
                    want = reports_due.pop_front();
                    if (o_pulse_total !== want.pulses)
                        note_mismatch("pulse_total", want.pulses, o_pulse_total);
                    if (o_position_count !== want.position)
                        note_mismatch("position_count", want.position, o_position_count);
                    if (o_speed_q16 !== want.speed)
                        note_mismatch("speed_q16", want.speed, o_speed_q16);
                end
            end
        end
    end

    // receiver back-pressure: mostly short stalls, now and then a long one
    always @(negedge i_clk) begin
        int roll;
        if (!i_rst_n || quiet) begin
            i_out_stall = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else begin
            roll = $urandom_range(0, 99);
            i_out_stall = 1'b0;
            if (roll < 12) begin
                i_out_stall = 1'b1;
                stall_left = $urandom_range(0, 2);
            end else if (roll < 14) begin
                i_out_stall = 1'b1;
                stall_left = $urandom_range(20, 60);
            end
        end
    end

    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // entered and left at a falling edge
    task automatic feed_sample(input logic a, input logic b, input logic typed,
                               input t_report rep);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_hall_a = a;
        i_hall_b = b;
        beat_typed = typed;
        beat_expect = rep;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // let every report drain, then allow for the two-stage output pipe
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (reports_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [hecs_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [hecs_pkg::CFG_BITS-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int walk_idx;
        int walk_dir;
        int roll;
        logic [1:0] pair;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_hall_a = 1'b0;
        i_hall_b = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = hecs_pkg::CFG_WINDOW_SAMPLES;
        i_cfg_data = '0;
        beat_typed = 1'b0;
        beat_expect = NO_REPORT;
        win_len = hecs_pkg::WINDOW_RESET;
        rpm_factor = hecs_pkg::FACTOR_RESET;
        prev_lv = '0;
        last_ph = hecs_pkg::PHASE_NONE;
        edges = '0;
        position = '0;
        win_cnt = '0;

        dir_rows = '{
            '{ROW_CONFIG, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd1, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd0, 32'sd0, 40'd0}},
            '{ROW_SAMPLE, 1'b0, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd1, 32'sd1, 40'd7680}},
            '{ROW_SAMPLE, 1'b1, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd1, 32'sd2, 40'd7680}},
            '{ROW_SAMPLE, 1'b1, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd0, 32'sd2, 40'd0}},
            '{ROW_SAMPLE, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd0, 32'sd2, 40'd0}},
            // both lines rise together, same phase as before: one event, down
            '{ROW_SAMPLE, 1'b1, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd1, 32'sd1, 40'd7680}},
            // zero window behaves as one
            '{ROW_CONFIG, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd0, 32'sd1, 40'd0}},
            '{ROW_SAMPLE, 1'b0, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd1, 32'sd0, 40'd7680}},
            '{ROW_SAMPLE, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd0, 32'sd0, 40'd0}},
            '{ROW_SAMPLE, 1'b1, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd1, 32'sd1, 40'd7680}},
            '{ROW_CONFIG, 1'b0, 1'b0, hecs_pkg::CFG_RPM_FACTOR, 24'hFFFFFF, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd0, 32'sd1, 40'd0}},
            '{ROW_SAMPLE, 1'b1, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd1, 32'sd0, 40'd16777215}},
            '{ROW_CONFIG, 1'b0, 1'b0, hecs_pkg::CFG_RPM_FACTOR, 24'd0, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b0, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd0, 32'sd0, 40'd0}},
            '{ROW_SAMPLE, 1'b1, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd1, 32'sd1, 40'd0}},
            '{ROW_CONFIG, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'hFFFFFF, 1'b0,
              NO_REPORT},
            '{ROW_CONFIG, 1'b0, 1'b0, hecs_pkg::CFG_RPM_FACTOR, 24'd7680, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b0, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b1, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b0, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b1, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT},
            // window dropped below the samples already seen: next beat reports
            '{ROW_CONFIG, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd3, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b1, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b1,
              '{16'd5, 32'sd0, 40'd38400}},
            '{ROW_SAMPLE, 1'b0, 1'b0, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b0, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT},
            '{ROW_SAMPLE, 1'b1, 1'b1, hecs_pkg::CFG_WINDOW_SAMPLES, 24'd0, 1'b0, NO_REPORT}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CONFIG) begin
                wait_idle();
                write_register(dir_rows[k].reg_index, dir_rows[k].reg_value);
            end else begin
                feed_sample(dir_rows[k].hall_a, dir_rows[k].hall_b,
                            dir_rows[k].has_report, dir_rows[k].report);
            end
        end

        walk_idx = 0;
        walk_dir = 1;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_idle();
            roll = $urandom_range(0, 99);
            if (roll < 10) write_register(hecs_pkg::CFG_WINDOW_SAMPLES, '0);
            else if (roll < 25)
                write_register(hecs_pkg::CFG_WINDOW_SAMPLES, hecs_pkg::CFG_BITS'(1));
            else if (roll < 85)
                write_register(hecs_pkg::CFG_WINDOW_SAMPLES,
                               hecs_pkg::CFG_BITS'($urandom_range(2, 12)));
            else
                write_register(hecs_pkg::CFG_WINDOW_SAMPLES,
                               hecs_pkg::CFG_BITS'($urandom_range(13, 40)));
            roll = $urandom_range(0, 99);
            if (roll < 15) write_register(hecs_pkg::CFG_RPM_FACTOR, '0);
            else if (roll < 30) write_register(hecs_pkg::CFG_RPM_FACTOR, 24'hFFFFFF);
            else
                write_register(hecs_pkg::CFG_RPM_FACTOR,
                               hecs_pkg::CFG_BITS'($urandom_range(0, 24'hFFFFFF)));
            quiet = (seg % 4 == 1);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    // noise: arbitrary level pair, may skip or reverse phases
                    pair = 2'($urandom);
                end else begin
                    if (roll < 25) walk_dir = -walk_dir;
                    else if (roll < 75) walk_idx = (walk_idx + walk_dir + 4) % 4;
                    pair = WALK_LEVELS[walk_idx*2 +: 2];
                end
                feed_sample(pair[1], pair[0], 1'b0, NO_REPORT);
            end
            quiet = 1'b0;
        end

        i_in_valid = 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
sv/hecs_pkg.sv
sv/hecs_tracker.sv
sv/hall_edge_counter_speed.sv
bench/testbench.sv
